// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the DRBG RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check sampled on clk, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/drbg_pkg.sv =====
// ----------------------------------------------------------------------------
// DRBG package
// Types, constants and AES helper functions for the CTR_DRBG block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drbg_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned SeedWords = 4;
  localparam int unsigned MaxRequestBytes = 256;
  localparam logic [31:0] ReseedLimitReset = 32'd1048576;
  localparam logic [31:0] CounterMax = 32'hFFFF_FFFF;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Control bundle from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic [BlockBits-1:0] key;
    logic [BlockBits-1:0] block;
  } aes_req_t;

  typedef struct packed {
    logic done;
    logic [BlockBits-1:0] result;
  } aes_rsp_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte 0 of the state sits in bits 127:120; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_round);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = final_round ? t[i] : m[i];
    end
    aes_round = o ^ rk;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96] ^ 32'h0;
    g = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
    w0 = k[127:96] ^ g;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== hw/rtl/drbg_aes_core.sv =====
// ----------------------------------------------------------------------------
// DRBG AES round unit
// Iterative AES-128 encryption: one round and one key expansion step a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drbg_aes_core (
  input  logic                clk,
  input  logic                rst,
  input  drbg_pkg::aes_req_t  req,
  output drbg_pkg::aes_rsp_t  rsp
);

  logic [127:0] state;
  logic [127:0] rkey;
  logic [7:0]   rcon;
  logic [3:0]   round;
  logic         busy;
  logic         done;
  logic [127:0] rk_next;

  assign rk_next = drbg_pkg::next_round_key(rkey, rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        state <= req.block ^ req.key;
        rkey <= req.key;
        rcon <= 8'h01;
        round <= 4'd1;
        busy <= 1'b1;
      end else if (busy) begin
        state <= drbg_pkg::aes_round(state, rk_next, round == 4'd10);
        rkey <= rk_next;
        rcon <= drbg_pkg::xtime(rcon);
        round <= round + 4'd1;
        if (round == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, result: state};

endmodule

// ===== hw/rtl/ctr_drbg_aes128.sv =====
// A seed word without last answers nothing; a last seed word with a bad count
// answers in the cycle after it is taken; a good seed answers after two AES
// blocks. A generate of n bytes runs ceil(n/16) + 2 AES blocks, then one beat
// per output word. One item at a time; input stalls while a result waits.
// Reset (rst, synchronous) clears key, V, counters and sets reseed_limit to 1048576.
// ----------------------------------------------------------------------------
// CTR_DRBG AES-128 top level
// Sequencer around a shared AES round unit: seeding, generate, update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctr_drbg_aes128 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] seed_word,
  input  logic        seed_last,
  input  logic [8:0]  byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_word,
  output logic [3:0]  valid_bytes,
  output logic        last,
  output logic        status,
  output logic        reseed_due,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  // Bytes the output buffer holds, and how many 64-bit words that is.
  localparam int unsigned BufWords = (drbg_pkg::MaxRequestBytes + 7) / 8;
  localparam int unsigned WIdxW = (BufWords > 1) ? $clog2(BufWords) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GEN    = 7'b0000010,
    S_GWAIT  = 7'b0000100,
    S_UPD    = 7'b0001000,
    S_UWAIT  = 7'b0010000,
    S_OUT    = 7'b0100000,
    S_SEEDR  = 7'b1000000
  } state_t;

  state_t state;

  logic [127:0] aes_key;
  logic [127:0] counter_block;
  logic [31:0]  reseed_counter;
  logic [31:0]  reseed_limit;
  logic [63:0]  seed_buffer [drbg_pkg::SeedWords];
  logic [2:0]   seed_words_seen;

  // Generated words live in a memory written once per AES block half.
  logic [63:0]  obuf [BufWords];
  logic [63:0]  obuf_rd;

  logic [8:0]   req_bytes;     // saturated request size
  logic [8:0]   gen_pos;       // bytes produced so far
  logic         upd_half;      // which half of the update block is running
  logic         is_seed;       // update is the seeding one
  logic [127:0] upd_lo;        // first update block
  logic         due;
  logic [WIdxW:0] out_idx;
  logic [WIdxW:0] out_cnt;
  logic         wr_phase;      // second word of an AES block pending write
  logic [127:0] wr_hold;
  logic [WIdxW-1:0] wr_addr;

  logic [127:0] v_inc;
  drbg_pkg::aes_req_t aes_req;
  drbg_pkg::aes_rsp_t aes_rsp;

  assign v_inc = counter_block + 128'd1;

  drbg_aes_core u_aes (
    .clk (clk),
    .rst (rst),
    .req (aes_req),
    .rsp (aes_rsp)
  );

  always_comb begin
    aes_req.start = 1'b0;
    aes_req.key = aes_key;
    aes_req.block = v_inc;
    unique case (state)
      S_GEN, S_UPD: aes_req.start = 1'b1;
      default: aes_req.start = 1'b0;
    endcase
  end

  // The output register frees the sequencer once the beat is taken.
  logic [3:0] vb_calc;
  logic [8:0] rem_bytes;
  assign rem_bytes = req_bytes - {out_idx[5:0] & 6'h3f, 3'b000};

  always_comb begin
    if (req_bytes == 9'd0) begin
      vb_calc = 4'd0;
    end else if (rem_bytes > 9'd8) begin
      vb_calc = 4'd8;
    end else begin
      vb_calc = rem_bytes[3:0];
    end
  end

  logic [63:0] byte_mask;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_mask[63 - 8*b -: 8] = (4'(b) < vb_calc) ? 8'hff : 8'h00;
    end
  end

  logic out_fire;
  assign out_fire = out_valid && !out_stall;
  logic out_pend;   // a word read from the buffer is ready to load

  // The first half of a finished block goes straight to its word; the second
  // half follows in the next cycle at the next word.
  always_ff @(posedge clk) begin
    if (wr_phase) begin
      obuf[wr_addr] <= wr_hold[63:0];
    end else if (aes_rsp.done && state == S_GWAIT) begin
      obuf[WIdxW'(gen_pos[8:3])] <= aes_rsp.result[127:64];
    end
    obuf_rd <= obuf[out_idx[WIdxW-1:0]];
  end

  // A beat waiting on the output holds the input off as well.
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      aes_key <= '0;
      counter_block <= '0;
      reseed_counter <= '0;
      reseed_limit <= drbg_pkg::ReseedLimitReset;
      seed_words_seen <= '0;
      out_valid <= 1'b0;
      wr_phase <= 1'b0;
      out_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        reseed_limit <= cfg_data;
      end
      if (out_fire && !(state == S_OUT && out_pend)) begin
        out_valid <= 1'b0;
      end
      if (wr_phase) begin
        wr_phase <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            if (!kind) begin
              if (seed_words_seen < 3'd4) begin
                seed_buffer[seed_words_seen[1:0]] <= seed_word;
              end
              if (seed_last) begin
                if (seed_words_seen == 3'd3) begin
                  is_seed <= 1'b1;
                  upd_half <= 1'b0;
                  state <= S_SEEDR;
                end else begin
                  random_word <= '0;
                  valid_bytes <= '0;
                  last <= 1'b1;
                  status <= 1'b1;
                  reseed_due <= 1'b0;
                  out_valid <= 1'b1;
                end
                seed_words_seen <= '0;
              end else if (seed_words_seen < 3'd7) begin
                seed_words_seen <= seed_words_seen + 3'd1;
              end
            end else begin
              due <= (reseed_counter > reseed_limit);
              req_bytes <= (byte_count > 9'(drbg_pkg::MaxRequestBytes)) ?
                           9'(drbg_pkg::MaxRequestBytes) : byte_count;
              gen_pos <= '0;
              is_seed <= 1'b0;
              upd_half <= 1'b0;
              if (byte_count == 9'd0) begin
                state <= S_UPD;
              end else begin
                state <= S_GEN;
              end
            end
          end
        end
        S_SEEDR: begin
          state <= S_UPD;
        end
        S_GEN: begin
          counter_block <= v_inc;
          state <= S_GWAIT;
        end
        S_GWAIT: begin
          if (aes_rsp.done) begin
            wr_addr <= WIdxW'(gen_pos[8:3] + 6'd1);
            wr_hold <= aes_rsp.result;
            wr_phase <= 1'b1;
            gen_pos <= gen_pos + 9'd16;
            state <= S_GEN;
            if (gen_pos + 9'd16 >= req_bytes) begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          counter_block <= v_inc;
          state <= S_UWAIT;
        end
        S_UWAIT: begin
          if (aes_rsp.done) begin
            if (!upd_half) begin
              upd_lo <= aes_rsp.result;
              upd_half <= 1'b1;
              state <= S_UPD;
            end else begin
              if (is_seed) begin
                aes_key <= upd_lo ^ {seed_buffer[0], seed_buffer[1]};
                counter_block <= aes_rsp.result ^ {seed_buffer[2], seed_buffer[3]};
                reseed_counter <= 32'd1;
                random_word <= '0;
                valid_bytes <= '0;
                last <= 1'b1;
                status <= 1'b0;
                reseed_due <= 1'b0;
                out_valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                aes_key <= upd_lo;
                counter_block <= aes_rsp.result;
                if (reseed_counter != drbg_pkg::CounterMax) begin
                  reseed_counter <= reseed_counter + 32'd1;
                end
                out_idx <= '0;
                out_cnt <= (req_bytes == 9'd0) ? (WIdxW+1)'(1) :
                           (WIdxW+1)'((req_bytes + 9'd7) >> 3);
                out_pend <= 1'b0;
                state <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          // The buffer read is registered: out_pend marks obuf_rd as current.
          if (!out_valid || out_fire) begin
            if (out_pend) begin
              random_word <= (req_bytes == 9'd0) ? 64'd0 : (obuf_rd & byte_mask);
              valid_bytes <= vb_calc;
              last <= (out_idx + (WIdxW+1)'(1) == out_cnt);
              status <= 1'b0;
              reseed_due <= due;
              out_valid <= 1'b1;
              out_pend <= 1'b0;
              if (out_idx + (WIdxW+1)'(1) == out_cnt) begin
                state <= S_IDLE;
              end else begin
                out_idx <= out_idx + (WIdxW+1)'(1);
              end
            end else begin
              out_pend <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall, "accepted while busy")
  `ASSERT_NEXT(a_seed_err_out, clk, rst,
    state == S_IDLE && in_valid && !in_stall && !out_valid && !kind && seed_last &&
    seed_words_seen != 3'd3, out_valid && status, "seed error not reported")
  `ASSERT_IMPL(a_valid_bytes_range, clk, rst, out_valid, valid_bytes <= 4'd8,
    "valid_bytes out of range")
  `ASSERT_IMPL(a_status_gen, clk, rst, out_valid && valid_bytes != 4'd0, !status,
    "status set on generate word")

endmodule
